/* rtl/core/abkf_pkg.sv */
`default_nettype none
package abkf_pkg;

  localparam int unsigned DtFracBits = 24;
  localparam int unsigned DataW      = 32;
  localparam int unsigned NoiseW     = 31;

  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;
  localparam logic [1:0] RegStartAngle   = 2'd3;

  localparam logic CmdUpdate  = 1'b0;
  localparam logic CmdRestart = 1'b1;

  typedef struct packed {
    logic              start;
    logic signed [65:0] num;
    logic signed [65:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [65:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                output logic             f);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      f  = 1'b0;
      if (v > mx) begin
        f = 1'b1;
        clip32 = 32'sh7fffffff;
      end else if (v < mn) begin
        f = 1'b1;
        clip32 = 32'sh80000000;
      end else begin
        clip32 = v[31:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/abkf_div.sv */
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module abkf_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire abkf_pkg::div_req_t req_i,
  output abkf_pkg::div_rsp_t     rsp_o
);

  localparam int unsigned W = 66;

  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic         neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [W:0]   trial;
  logic [W-1:0] shifted;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    shifted = {rem_q[W-2:0], quo_q[W-1]};
    trial   = {1'b0, shifted} - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num[W-1] ? W'(-req_i.num) : W'(req_i.num);
      dvs_d  = req_i.den[W-1] ? W'(-req_i.den) : W'(req_i.den);
      neg_d  = req_i.num[W-1] ^ req_i.den[W-1];
      busy_d = 1'b1;
      cnt_d  = 7'(W);
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

/* rtl/core/abkf_mac.sv */
`default_nettype none
// Shared multiplier: signed 33x34 product, rounded right shift, then added to
// or subtracted from the addend.
module abkf_mac (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [33:0] b_i,
  input  wire logic [5:0]         shift_i,
  input  wire logic signed [65:0] add_i,
  input  wire logic               sub_i,
  output logic signed [65:0]      res_o
);

  logic signed [65:0] prod_q;
  logic [5:0]         shift_q;
  logic signed [65:0] add_q;
  logic               sub_q;
  logic signed [66:0] rnd;

  always_ff @(posedge clk_i) begin
    prod_q  <= 66'(a_i) * 66'(b_i);
    shift_q <= shift_i;
    add_q   <= add_i;
    sub_q   <= sub_i;
  end

  always_comb begin
    rnd   = (67'(prod_q) + (67'sd1 <<< (shift_q - 6'd1))) >>> shift_q;
    res_o = sub_q ? add_q - 66'(rnd) : add_q + 66'(rnd);
  end

endmodule
`default_nettype wire

/* rtl/core/angle_bias_kalman_filter_unit.sv */
`default_nettype none
// Angle / gyro-bias Kalman filter, fixed point.
// Slave stream carries one request: tuser = command (0 update, 1 restart),
// tdata = measured_angle, rate_in, time_step. Master stream returns
// tdata = angle_out, bias_out and tuser = saturated.
// Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i, written while idle.
// Index 0 angle_noise, 1 bias_noise, 2 measure_noise, 3 start_angle.
// An update runs a sequencer over one shared multiplier and one radix-2
// divider (used once per gain, two gains); the divider is skipped when the
// innovation variance is zero. A new request is taken only after the
// previous result has been accepted.
// s_axis_tready is high only when the core is idle and no result is held.
// The result sits in an output register until m_axis_tready; the core
// waits meanwhile. Reset clears state to angle 0, bias 0, P = identity and
// loads the register defaults.
module angle_bias_kalman_filter_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned COV_FRAC_BITS   = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] measured_angle, [63:32] rate_in, [87:64] time_step
  input  wire logic [87:0]  s_axis_tdata,
  // [0] command
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] angle_out, [63:32] bias_out
  output logic [63:0]       m_axis_tdata,
  // [0] saturated
  output logic              m_axis_tuser
);

  localparam logic [5:0] DtSh  = 6'(abkf_pkg::DtFracBits);
  localparam logic [5:0] CovSh = 6'(COV_FRAC_BITS);
  localparam logic signed [65:0] One = 66'sd1 <<< COV_FRAC_BITS;

  localparam logic [4:0] StIdle = 5'd0,  StAng = 5'd1,  StT = 5'd2,
                         StQ00 = 5'd3,   StGo0 = 5'd4,  StW0 = 5'd5,
                         StGo1 = 5'd6,   StW1 = 5'd7,   StCa = 5'd8,
                         StCb = 5'd9,    StP0 = 5'd10,  StP1 = 5'd11,
                         StP2 = 5'd12,   StP3 = 5'd13,  StOut = 5'd14;

  logic [4:0] st_q;
  logic       ph_q;
  logic [30:0] an_q, bn_q, mn_q;
  logic signed [31:0] sa_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] q00_q, q01_q, q10_q, q11_q, k0_q, k1_q;
  logic signed [65:0] t_q, y_q;
  logic signed [31:0] meas_q, gyro_q;
  logic [23:0]        dt_q;
  logic               sat_q, ov_q;
  logic [63:0]        odata_q;
  logic               ouser_q;

  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic [5:0]         msh;
  logic               msub;
  logic signed [65:0] madd, mres;
  abkf_pkg::div_req_t dreq;
  abkf_pkg::div_rsp_t drsp;
  logic signed [65:0] sden;
  logic               f;
  logic signed [31:0] c;

  abkf_mac u_mac (.clk_i, .a_i(ma), .b_i(mb), .shift_i(msh), .add_i(madd),
                  .sub_i(msub), .res_o(mres));
  abkf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign sden = 66'(q00_q) + 66'($signed({1'b0, mn_q}));
  assign s_axis_tready = (st_q == StIdle) && !ov_q;

  always_comb begin
    ma = '0; mb = '0; msh = DtSh; madd = '0; msub = 1'b0;
    unique case (st_q)
      StAng: begin
        ma = 33'(gyro_q) - 33'(bias_q); mb = 34'($signed({1'b0, dt_q}));
        madd = 66'(ang_q);
      end
      StT: begin
        ma = 33'($signed({1'b0, dt_q})); mb = 34'(p11_q);
      end
      StQ00: begin
        ma = 33'($signed({1'b0, dt_q}));
        mb = 34'(t_q - 66'(p01_q) - 66'(p10_q));
        madd = 66'(p00_q) + 66'($signed({1'b0, an_q}));
      end
      StCa: begin
        ma = 33'(k0_q); mb = 34'(y_q); msh = CovSh; madd = 66'(ang_q);
      end
      StCb: begin
        ma = 33'(k1_q); mb = 34'(y_q); msh = CovSh; madd = 66'(bias_q);
      end
      StP0: begin
        ma = 33'(One - 66'(k0_q)); mb = 34'(q00_q); msh = CovSh;
      end
      StP1: begin
        ma = 33'(One - 66'(k0_q)); mb = 34'(q01_q); msh = CovSh;
      end
      StP2: begin
        ma = 33'(k1_q); mb = 34'(q00_q); msh = CovSh; madd = 66'(q10_q);
        msub = 1'b1;
      end
      StP3: begin
        ma = 33'(k1_q); mb = 34'(q01_q); msh = CovSh; madd = 66'(q11_q);
        msub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.den   = sden;
    dreq.num   = (st_q == StGo0) ? 66'(q00_q) <<< COV_FRAC_BITS
                                 : 66'(q10_q) <<< COV_FRAC_BITS;
    if ((st_q == StGo0 || st_q == StGo1) && sden != 0) dreq.start = 1'b1;
  end

  always_comb begin
    c = abkf_pkg::clip32(mres, f);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ph_q <= 1'b0; ov_q <= 1'b0;
      an_q <= 31'd16777; bn_q <= 31'd50332; mn_q <= 31'd503316; sa_q <= '0;
      ang_q <= '0; bias_q <= '0; p01_q <= '0; p10_q <= '0;
      p00_q <= 32'(One); p11_q <= 32'(One);
      q00_q <= '0; q01_q <= '0; q10_q <= '0; q11_q <= '0;
      k0_q <= '0; k1_q <= '0; t_q <= '0; y_q <= '0;
      meas_q <= '0; gyro_q <= '0; dt_q <= '0; sat_q <= 1'b0;
      odata_q <= '0; ouser_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          abkf_pkg::RegAngleNoise:   an_q <= cfg_wdata_i[30:0];
          abkf_pkg::RegBiasNoise:    bn_q <= cfg_wdata_i[30:0];
          abkf_pkg::RegMeasureNoise: mn_q <= cfg_wdata_i[30:0];
          abkf_pkg::RegStartAngle:   sa_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          sat_q <= 1'b0;
          if (s_axis_tuser == abkf_pkg::CmdRestart) begin
            ang_q <= sa_q; bias_q <= '0; p01_q <= '0; p10_q <= '0;
            p00_q <= 32'(One); p11_q <= 32'(One);
            st_q <= StOut;
          end else begin
            meas_q <= s_axis_tdata[31:0]; gyro_q <= s_axis_tdata[63:32];
            dt_q <= s_axis_tdata[87:64];
            st_q <= StAng;
          end
        end
        StAng, StT, StQ00, StCa, StCb, StP0, StP1, StP2, StP3: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            unique case (st_q)
              StAng: begin ang_q <= c; sat_q <= sat_q | f; st_q <= StT; end
              StT: begin
                t_q <= mres;
                st_q <= StQ00;
              end
              StQ00: begin q00_q <= c; sat_q <= sat_q | f; st_q <= StGo0; end
              StCa: begin
                ang_q <= c; sat_q <= sat_q | f; st_q <= StCb;
              end
              StCb: begin
                bias_q <= c; sat_q <= sat_q | f; st_q <= StP0;
              end
              StP0: begin p00_q <= c; sat_q <= sat_q | f; st_q <= StP1; end
              StP1: begin p01_q <= c; sat_q <= sat_q | f; st_q <= StP2; end
              StP2: begin p10_q <= c; sat_q <= sat_q | f; st_q <= StP3; end
              default: begin
                p11_q <= c; sat_q <= sat_q | f; st_q <= StOut;
              end
            endcase
          end
        end
        StGo0: begin
          // t known: finish q01/q10/q11 saturation flags here
          begin : q_blk
            logic f1, f2, f3;
            q01_q <= abkf_pkg::clip32(66'(p01_q) - t_q, f1);
            q10_q <= abkf_pkg::clip32(66'(p10_q) - t_q, f2);
            q11_q <= abkf_pkg::clip32(66'(p11_q) + 66'($signed({1'b0, bn_q})), f3);
            sat_q <= sat_q | f1 | f2 | f3;
          end
          k0_q <= '0; k1_q <= '0;
          st_q <= (sden != 0) ? StW0 : StCa;
          y_q  <= 66'(meas_q) - 66'(ang_q);
        end
        StW0: if (drsp.done) begin : k0_blk
          logic fk;
          k0_q <= abkf_pkg::clip32(drsp.quot, fk);
          sat_q <= sat_q | fk;
          st_q <= StGo1;
        end
        StGo1: st_q <= StW1;
        StW1: if (drsp.done) begin : k1_blk
          logic fk;
          k1_q <= abkf_pkg::clip32(drsp.quot, fk);
          sat_q <= sat_q | fk;
          st_q <= StCa;
        end
        StOut: begin
          odata_q <= {bias_q, ang_q}; ouser_q <= sat_q; ov_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule
`default_nettype wire

/* rtl/core/abkf_checker.sv */
`default_nettype none
module abkf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result pending");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid || !s_axis_tready)
    else $error("no progress after request");

endmodule

bind angle_bias_kalman_filter_unit abkf_checker u_abkf_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AFB = 16;
  localparam int unsigned CFB = 24;

  typedef struct packed {
    logic        cmd;
    logic [31:0] meas;
    logic [31:0] rate;
    logic [23:0] dt;
  } kf_req_t;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] bias;
    logic        sat;
  } kf_est_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  angle_bias_kalman_filter_unit #(.ANGLE_FRAC_BITS(AFB), .COV_FRAC_BITS(CFB)) dut (.*);

  always #6 clk_i = ~clk_i;

  // filter model state
  logic [30:0]        q_angle, q_bias, r_meas;
  logic signed [31:0] a_start, ang, bia;
  logic signed [31:0] cov [4];

  kf_req_t req_q[$];
  kf_est_t est_q[$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  s_gap = 0, m_gap = 0;

  function automatic logic signed [65:0] rnd_shift(input logic signed [127:0] v, input int s);
    logic signed [127:0] t;
    t = (v + (128'sd1 <<< (s - 1))) >>> s;
    return t[65:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v, inout logic f);
    if (v > 66'sd2147483647) begin
      f = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void kf_reset();
    q_angle = 31'd16777;
    q_bias  = 31'd50332;
    r_meas  = 31'd503316;
    a_start = 0;
    ang = 0;
    bia = 0;
    cov[0] = 32'sd1 <<< CFB;
    cov[1] = 0;
    cov[2] = 0;
    cov[3] = 32'sd1 <<< CFB;
  endfunction

  function automatic kf_est_t kf_step(input kf_req_t r);
    logic               f;
    logic signed [65:0] one, p00, p01, p10, p11, rt, dt, t, q00, q01, q10, q11, s, k0, k1, y;
    logic signed [127:0] prod;
    kf_est_t            e;
    f = 1'b0;
    one = 66'sd1 <<< CFB;
    if (r.cmd == abkf_pkg::CmdRestart) begin
      ang = a_start;
      bia = 0;
      cov[0] = one[31:0];
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = one[31:0];
    end else begin
      p00 = cov[0];
      p01 = cov[1];
      p10 = cov[2];
      p11 = cov[3];
      dt = $signed({42'd0, r.dt});
      rt = $signed(r.rate) - bia;
      ang = sat32(ang + rnd_shift(rt * dt, abkf_pkg::DtFracBits), f);
      t = rnd_shift(dt * p11, abkf_pkg::DtFracBits);
      q00 = sat32(p00 + rnd_shift(dt * (t - p01 - p10), abkf_pkg::DtFracBits)
                  + $signed({35'd0, q_angle}), f);
      q01 = sat32(p01 - t, f);
      q10 = sat32(p10 - t, f);
      q11 = sat32(p11 + $signed({35'd0, q_bias}), f);
      s = q00 + $signed({35'd0, r_meas});
      k0 = 0;
      k1 = 0;
      if (s != 0) begin
        prod = q00 * one;
        k0 = sat32(prod / s, f);
        prod = q10 * one;
        k1 = sat32(prod / s, f);
      end
      y = $signed(r.meas) - ang;
      ang = sat32(ang + rnd_shift(k0 * y, CFB), f);
      bia = sat32(bia + rnd_shift(k1 * y, CFB), f);
      cov[0] = sat32(rnd_shift((one - k0) * q00, CFB), f);
      cov[1] = sat32(rnd_shift((one - k0) * q01, CFB), f);
      cov[2] = sat32(q10 - rnd_shift(k1 * q00, CFB), f);
      cov[3] = sat32(q11 - rnd_shift(k1 * q01, CFB), f);
    end
    e.angle = ang;
    e.bias = bia;
    e.sat = f;
    return e;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        est_q.push_back(kf_step({s_axis_tuser, s_axis_tdata[31:0],
                                 s_axis_tdata[63:32], s_axis_tdata[87:64]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_gap > 0) begin
          s_gap <= s_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(7) == 0) begin
          s_gap <= $urandom_range(13, 1) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          kf_req_t r;
          r = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= r.cmd;
          s_axis_tdata  <= {r.dt, r.rate, r.meas};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (est_q.size() == 0) begin
          $display("%t unexpected result: actual %h/%b", $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          kf_est_t e;
          e = est_q.pop_front();
          if (m_axis_tdata[31:0] !== e.angle) begin
            $display("%t angle_out: expected %h actual %h", $time, e.angle, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[63:32] !== e.bias) begin
            $display("%t bias_out: expected %h actual %h", $time, e.bias, m_axis_tdata[63:32]);
            errors++;
          end
          if (m_axis_tuser !== e.sat) begin
            $display("%t saturated: expected %b actual %b", $time, e.sat, m_axis_tuser);
            errors++;
          end
        end
      end
      if (m_gap > 0) begin
        m_gap <= m_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(5) == 0) begin
        m_gap <= $urandom_range(13, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(20000) - 10000;
      3: return 32'h00000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic kf_req_t rnd_req(input bit wild);
    kf_req_t r;
    r.cmd = ($urandom_range(24) == 0) ? abkf_pkg::CmdRestart : abkf_pkg::CmdUpdate;
    if (wild) begin
      r.meas = rnd_val();
      r.rate = rnd_val();
      r.dt = $urandom_range(3) == 0 ? 24'hffffff : 24'($urandom());
    end else begin
      r.meas = $urandom_range(32'h00b40000) - 32'h005a0000;
      r.rate = $urandom_range(32'h01000000) - 32'h00800000;
      r.dt = 24'($urandom_range(20000, 1));
    end
    return r;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == abkf_pkg::RegAngleNoise) q_angle = v[30:0];
    else if (idx == abkf_pkg::RegBiasNoise) q_bias = v[30:0];
    else if (idx == abkf_pkg::RegMeasureNoise) r_meas = v[30:0];
    else a_start = v;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || s_axis_tvalid || est_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    kf_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'h00010000, 32'h0, 24'd10000});
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'h7fffffff, 32'h7fffffff, 24'hffffff});
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'h80000000, 32'h80000000, 24'hffffff});
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'h0, 32'h0, 24'd0});
    req_q.push_back('{abkf_pkg::CmdRestart, 32'hffffffff, 32'hffffffff, 24'hffffff});
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'hffffffff, 32'h00000001, 24'd1});
    drain();
    cfg_write(abkf_pkg::RegAngleNoise, 32'h0);
    cfg_write(abkf_pkg::RegBiasNoise, 32'h0);
    cfg_write(abkf_pkg::RegMeasureNoise, 32'h0);
    cfg_write(abkf_pkg::RegStartAngle, 32'h80000000);
    // zero noise registers, then a restart and updates
    req_q.push_back('{abkf_pkg::CmdRestart, 32'h0, 32'h0, 24'd0});
    req_q.push_back('{abkf_pkg::CmdUpdate, 32'h1234, 32'h0, 24'd0});
    for (int i = 0; i < 6; i++) req_q.push_back(rnd_req(1));
    drain();
    cfg_write(abkf_pkg::RegAngleNoise, 32'h7fffffff);
    cfg_write(abkf_pkg::RegBiasNoise, 32'h7fffffff);
    cfg_write(abkf_pkg::RegMeasureNoise, 32'h7fffffff);
    cfg_write(abkf_pkg::RegStartAngle, 32'h7fffffff);
    req_q.push_back('{abkf_pkg::CmdRestart, 32'h0, 32'h0, 24'd0});
    for (int i = 0; i < 6; i++) req_q.push_back(rnd_req(1));
    drain();
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(abkf_pkg::RegAngleNoise,
                $urandom_range(4) == 0 ? $urandom() : $urandom_range(100000));
      cfg_write(abkf_pkg::RegBiasNoise,
                $urandom_range(4) == 0 ? $urandom() : $urandom_range(100000));
      cfg_write(abkf_pkg::RegMeasureNoise,
                $urandom_range(4) == 0 ? $urandom() : $urandom_range(2000000));
      cfg_write(abkf_pkg::RegStartAngle, rnd_val());
      if (ph == 5) calm = 1'b1;
      req_q.push_back('{abkf_pkg::CmdRestart, 32'h0, 32'h0, 24'd0});
      for (int i = 0; i < 300; i++) req_q.push_back(rnd_req($urandom_range(4) == 0));
      drain();
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
rtl/core/abkf_pkg.sv
rtl/core/abkf_div.sv
rtl/core/abkf_mac.sv
rtl/core/angle_bias_kalman_filter_unit.sv
rtl/core/abkf_checker.sv
dv/tb_top.sv
